### design/size_class_buffer_pool_defines.svh
// ----------------------------------------------------------------------------
// size class buffer pool assertion macros
// shared checking macros, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BUFFER_POOL_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_DEFINES_SVH

`ifndef SYNTHESIS
`define SCBP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SCBP_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SCBP_ASSERT(lbl, clk, rstn, prop, msg)
`define SCBP_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### design/scbp_pkg.sv
// ----------------------------------------------------------------------------
// scbp_pkg
// types, constants and class tables of the size class buffer pool
// ----------------------------------------------------------------------------
package scbp_pkg;

	localparam int NUM_CLASSES = 7;
	localparam int HANDLES     = 8192;
	localparam int HANDLE_W    = 13;
	localparam int COUNT_W     = 14;
	localparam int CLASS_W     = 3;
	localparam int BYTES_W     = 31;
	localparam int KB_W        = 14;
	localparam int SHIFT_W     = 4;
	localparam int PK_W        = 28;
	localparam int LIMIT_W     = 32;
	localparam int NEED_W      = 34;
	localparam int REG_IDX_W   = 3;
	localparam int PADDR_W     = REG_IDX_W + 2;
	localparam int PDATA_W     = 32;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;
	localparam int RAM_DEPTH   = NUM_CLASSES * HANDLES;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);

	localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 32'd5242880;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd0;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_ALLOCATED   = 3'd0,
		ST_RELEASED    = 3'd1,
		ST_TOO_LARGE   = 3'd2,
		ST_OVER_LIMIT  = 3'd3,
		ST_EXHAUSTED   = 3'd4,
		ST_BAD_RELEASE = 3'd5
	} status_t;

	typedef enum logic {
		B_IDLE,
		B_RD
	} back_state_t;

	typedef logic [COUNT_W-1:0] count_t;
	typedef count_t [NUM_CLASSES-1:0] prealloc_vec_t;

	typedef struct packed {
		logic                is_release;
		logic                bad;
		logic [CLASS_W-1:0]  cls;
		logic [HANDLE_W-1:0] handle;
	} q_entry_t;

	function automatic logic [KB_W-1:0] class_kb(input logic [CLASS_W-1:0] c);
		logic [KB_W-1:0] kb;
		unique case (c)
			3'd0:    kb = 14'd4;
			3'd1:    kb = 14'd16;
			3'd2:    kb = 14'd64;
			3'd3:    kb = 14'd256;
			3'd4:    kb = 14'd1024;
			3'd5:    kb = 14'd4096;
			3'd6:    kb = 14'd8192;
			default: kb = 14'd0;
		endcase
		return kb;
	endfunction

	function automatic logic [SHIFT_W-1:0] class_shift(input logic [CLASS_W-1:0] c);
		logic [SHIFT_W-1:0] s;
		unique case (c)
			3'd0:    s = 4'd2;
			3'd1:    s = 4'd4;
			3'd2:    s = 4'd6;
			3'd3:    s = 4'd8;
			3'd4:    s = 4'd10;
			3'd5:    s = 4'd12;
			3'd6:    s = 4'd13;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic count_t prealloc_reset(input logic [CLASS_W-1:0] c);
		count_t v;
		unique case (c)
			3'd0:    v = 14'd5000;
			3'd1:    v = 14'd1000;
			3'd2:    v = 14'd500;
			3'd3:    v = 14'd200;
			3'd4:    v = 14'd50;
			3'd5:    v = 14'd20;
			3'd6:    v = 14'd10;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

	function automatic logic [RAM_AW-1:0] ram_addr(input logic [CLASS_W-1:0] c,
			input logic [HANDLE_W-1:0] idx);
		return (RAM_AW'(c) << HANDLE_W) | RAM_AW'(idx);
	endfunction

endpackage

### design/size_class_buffer_pool.sv
// ----------------------------------------------------------------------------
// size_class_buffer_pool
// buffer manager with seven size classes, free stacks and a kb budget
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one allocate or release item;
//   output channel (out_valid/out_ready) returns one status item per input,
//   in order. an allocate grants a handle from the class free stack or mints
//   a new one, past the preallocated count only within the kb limit; a
//   release pushes the handle back. each result passes through the queue
//   and the output register; a stack pop also waits in B_RD for the
//   registered read of the shared stack ram. throughput: one item per cycle
//   for mints and releases while out_ready holds; none is taken in B_RD.
//   a 2-entry queue lets the input side keep accepting while a result waits.
//   reset clears stack depths, mint counts and the tally at once; the stack
//   ram is not cleared, so items are accepted right after reset.
//   if the receiver stalls the result holds, the queue fills, in_ready drops.
//   the user must write the apb registers only while idle; not enforced.
// ----------------------------------------------------------------------------
module size_class_buffer_pool (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scbp_pkg::PADDR_W-1:0]  paddr,
	input  logic [scbp_pkg::PDATA_W-1:0]  pwdata,
	output logic [scbp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [scbp_pkg::BYTES_W-1:0]  request_bytes,
	input  logic [scbp_pkg::CLASS_W-1:0]  release_class,
	input  logic [scbp_pkg::HANDLE_W-1:0] release_handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [scbp_pkg::CLASS_W-1:0]  granted_class,
	output logic [scbp_pkg::HANDLE_W-1:0] granted_handle
);

	logic [scbp_pkg::LIMIT_W-1:0]   limit_q;
	scbp_pkg::prealloc_vec_t        prealloc_q;
	logic [scbp_pkg::REG_IDX_W-1:0] reg_idx;
	logic [scbp_pkg::REG_IDX_W-1:0] pre_idx;
	logic                           cfg_wr;

	scbp_pkg::q_entry_t             push_entry;
	scbp_pkg::q_entry_t             head;
	logic                           q_push;
	logic                           q_pop;
	logic                           q_full;
	logic                           q_valid;
	scbp_pkg::status_t              out_status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[scbp_pkg::PADDR_W-1:2];
	assign pre_idx = reg_idx - 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		if (reg_idx == scbp_pkg::REG_LIMIT) begin
			prdata = limit_q;
		end else begin
			prdata = scbp_pkg::PDATA_W'(prealloc_q[pre_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= scbp_pkg::LIMIT_RESET;
			for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
				prealloc_q[c] <= scbp_pkg::prealloc_reset(scbp_pkg::CLASS_W'(c));
			end
		end else if (cfg_wr) begin
			if (reg_idx == scbp_pkg::REG_LIMIT) begin
				limit_q <= pwdata[scbp_pkg::LIMIT_W-1:0];
			end else begin
				prealloc_q[pre_idx] <= pwdata[scbp_pkg::COUNT_W-1:0];
			end
		end
	end

	scbp_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.request_bytes (request_bytes),
		.release_class (release_class),
		.release_handle(release_handle),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (push_entry)
	);

	scbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head)
	);

	scbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (head),
		.q_pop     (q_pop),
		.limit_kb  (limit_q),
		.prealloc  (prealloc_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_status(out_status),
		.out_class (granted_class),
		.out_handle(granted_handle)
	);

	assign status = out_status;

endmodule

### design/scbp_ram.sv
// ----------------------------------------------------------------------------
// scbp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module scbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/scbp_front.sv
// ----------------------------------------------------------------------------
// scbp_front
// input side: maps request size to a class and screens release items
// ----------------------------------------------------------------------------
module scbp_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [scbp_pkg::BYTES_W-1:0]  request_bytes,
	input  logic [scbp_pkg::CLASS_W-1:0]  release_class,
	input  logic [scbp_pkg::HANDLE_W-1:0] release_handle,
	input  logic                          q_full,
	output logic                          q_push,
	output scbp_pkg::q_entry_t            q_entry
);

	logic                         found;
	logic [scbp_pkg::CLASS_W-1:0] size_cls;
	logic                         rel_bad;

	// smallest class that holds the request
	always_comb begin
		found    = 1'b0;
		size_cls = '0;
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
			if (!found && request_bytes <= (scbp_pkg::BYTES_W'(
					scbp_pkg::class_kb(scbp_pkg::CLASS_W'(c))) << 10)) begin
				found    = 1'b1;
				size_cls = scbp_pkg::CLASS_W'(c);
			end
		end
	end

	assign rel_bad = (release_class >= scbp_pkg::CLASS_W'(scbp_pkg::NUM_CLASSES)) ||
		(scbp_pkg::COUNT_W'(release_handle) >= scbp_pkg::COUNT_W'(scbp_pkg::HANDLES));

	always_comb begin
		q_entry.is_release = (action == scbp_pkg::ACT_RELEASE);
		q_entry.handle     = release_handle;
		if (action == scbp_pkg::ACT_RELEASE) begin
			q_entry.bad = rel_bad;
			q_entry.cls = rel_bad ? '0 : release_class;
		end else begin
			q_entry.bad = !found;
			q_entry.cls = size_cls;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

### design/scbp_queue.sv
// ----------------------------------------------------------------------------
// scbp_queue
// short fifo between the classifying front and the executing back
// ----------------------------------------------------------------------------
module scbp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  scbp_pkg::q_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output scbp_pkg::q_entry_t head
);

	scbp_pkg::q_entry_t            slot_q [scbp_pkg::QDEPTH];
	logic [scbp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [scbp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [scbp_pkg::QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == scbp_pkg::QCNT_W'(scbp_pkg::QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/scbp_back.sv
// ----------------------------------------------------------------------------
// scbp_back
// execution side: per-class free stacks, mint counters, kb tally, result
// ----------------------------------------------------------------------------
`include "size_class_buffer_pool_defines.svh"

module scbp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  scbp_pkg::q_entry_t            q_entry,
	output logic                          q_pop,
	input  logic [scbp_pkg::LIMIT_W-1:0]  limit_kb,
	input  scbp_pkg::prealloc_vec_t       prealloc,
	output logic                          out_valid,
	input  logic                          out_ready,
	output scbp_pkg::status_t             out_status,
	output logic [scbp_pkg::CLASS_W-1:0]  out_class,
	output logic [scbp_pkg::HANDLE_W-1:0] out_handle
);

	scbp_pkg::back_state_t         state_q, state_d;
	scbp_pkg::count_t              stack_cnt_q [scbp_pkg::NUM_CLASSES];
	scbp_pkg::count_t              minted_q [scbp_pkg::NUM_CLASSES];
	logic [scbp_pkg::LIMIT_W-1:0]  tally_q;
	logic [scbp_pkg::PK_W-1:0]     pk_sum;
	logic [scbp_pkg::PK_W-1:0]     prealloc_kb_q;
	logic [scbp_pkg::CLASS_W-1:0]  pend_cls_q;
	logic                          out_valid_q;
	scbp_pkg::status_t             out_status_q;
	logic [scbp_pkg::CLASS_W-1:0]  out_class_q;
	logic [scbp_pkg::HANDLE_W-1:0] out_handle_q;

	logic                          out_free;
	logic                          start;
	logic                          pop_hit;
	scbp_pkg::count_t              cnt_sel;
	scbp_pkg::count_t              minted_sel;
	scbp_pkg::count_t              cnt_dec;
	logic [scbp_pkg::KB_W-1:0]     kb_sel;
	logic [scbp_pkg::NEED_W-1:0]   need;
	logic [scbp_pkg::LIMIT_W:0]    tally_sum;

	logic                          load_out;
	scbp_pkg::status_t             res_status;
	logic [scbp_pkg::CLASS_W-1:0]  res_cls;
	logic [scbp_pkg::HANDLE_W-1:0] res_hnd;
	logic                          stack_inc;
	logic                          stack_dec;
	logic                          minted_inc;
	logic                          tally_upd;
	logic                          ram_we;
	logic                          ram_re;
	logic [scbp_pkg::RAM_AW-1:0]   ram_waddr;
	logic [scbp_pkg::RAM_AW-1:0]   ram_raddr;
	logic [scbp_pkg::HANDLE_W-1:0] ram_rdata;

	// kb held by preallocated handles
	always_comb begin
		pk_sum = '0;
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
			pk_sum = pk_sum + (scbp_pkg::PK_W'(prealloc[c]) <<
				scbp_pkg::class_shift(scbp_pkg::CLASS_W'(c)));
		end
	end

	always_ff @(posedge clk) begin
		prealloc_kb_q <= pk_sum;
	end

	assign out_free   = !out_valid_q || out_ready;
	assign start      = (state_q == scbp_pkg::B_IDLE) && q_valid && out_free;
	assign cnt_sel    = stack_cnt_q[q_entry.cls];
	assign minted_sel = minted_q[q_entry.cls];
	assign cnt_dec    = cnt_sel - 1'b1;
	assign kb_sel     = scbp_pkg::class_kb(q_entry.cls);
	assign pop_hit    = !q_entry.is_release && !q_entry.bad && (cnt_sel != '0);
	assign need       = scbp_pkg::NEED_W'(prealloc_kb_q) + scbp_pkg::NEED_W'(tally_q) +
		scbp_pkg::NEED_W'(kb_sel);
	assign tally_sum  = (scbp_pkg::LIMIT_W + 1)'(tally_q) + (scbp_pkg::LIMIT_W + 1)'(kb_sel);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scbp_pkg::B_IDLE: begin
				if (start && pop_hit) begin
					state_d = scbp_pkg::B_RD;
				end
			end
			scbp_pkg::B_RD: begin
				state_d = scbp_pkg::B_IDLE;
			end
			default: state_d = scbp_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		load_out   = 1'b0;
		res_status = scbp_pkg::ST_ALLOCATED;
		res_cls    = '0;
		res_hnd    = '0;
		stack_inc  = 1'b0;
		stack_dec  = 1'b0;
		minted_inc = 1'b0;
		tally_upd  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = scbp_pkg::ram_addr(q_entry.cls, cnt_sel[scbp_pkg::HANDLE_W-1:0]);
		ram_raddr  = scbp_pkg::ram_addr(q_entry.cls, cnt_dec[scbp_pkg::HANDLE_W-1:0]);
		unique case (state_q)
			scbp_pkg::B_IDLE: begin
				if (start) begin
					q_pop = 1'b1;
					if (q_entry.is_release) begin
						load_out = 1'b1;
						if (q_entry.bad ||
								cnt_sel >= scbp_pkg::COUNT_W'(scbp_pkg::HANDLES)) begin
							res_status = scbp_pkg::ST_BAD_RELEASE;
						end else begin
							res_status = scbp_pkg::ST_RELEASED;
							ram_we     = 1'b1;
							stack_inc  = 1'b1;
						end
					end else if (q_entry.bad) begin
						load_out   = 1'b1;
						res_status = scbp_pkg::ST_TOO_LARGE;
					end else if (pop_hit) begin
						ram_re    = 1'b1;
						stack_dec = 1'b1;
					end else if (minted_sel >= scbp_pkg::COUNT_W'(scbp_pkg::HANDLES)) begin
						load_out   = 1'b1;
						res_status = scbp_pkg::ST_EXHAUSTED;
					end else if (minted_sel < prealloc[q_entry.cls]) begin
						load_out   = 1'b1;
						minted_inc = 1'b1;
						res_cls    = q_entry.cls;
						res_hnd    = minted_sel[scbp_pkg::HANDLE_W-1:0];
					end else if (need >= scbp_pkg::NEED_W'(limit_kb)) begin
						load_out   = 1'b1;
						res_status = scbp_pkg::ST_OVER_LIMIT;
					end else begin
						load_out   = 1'b1;
						minted_inc = 1'b1;
						tally_upd  = 1'b1;
						res_cls    = q_entry.cls;
						res_hnd    = minted_sel[scbp_pkg::HANDLE_W-1:0];
					end
				end
			end
			scbp_pkg::B_RD: begin
				load_out   = 1'b1;
				res_status = scbp_pkg::ST_ALLOCATED;
				res_cls    = pend_cls_q;
				res_hnd    = ram_rdata;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	scbp_ram #(
		.WIDTH(scbp_pkg::HANDLE_W),
		.DEPTH(scbp_pkg::RAM_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(q_entry.handle),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scbp_pkg::B_IDLE;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
				stack_cnt_q[c] <= '0;
				minted_q[c]    <= '0;
			end
		end else begin
			state_q <= state_d;
			if (stack_inc) begin
				stack_cnt_q[q_entry.cls] <= cnt_sel + 1'b1;
			end else if (stack_dec) begin
				stack_cnt_q[q_entry.cls] <= cnt_dec;
			end
			if (minted_inc) begin
				minted_q[q_entry.cls] <= minted_sel + 1'b1;
			end
			if (tally_upd) begin
				tally_q <= tally_sum[scbp_pkg::LIMIT_W] ? '1 :
					tally_sum[scbp_pkg::LIMIT_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pend_cls_q <= q_entry.cls;
		end
		if (load_out) begin
			out_status_q <= res_status;
			out_class_q  <= res_cls;
			out_handle_q <= res_hnd;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_class  = out_class_q;
	assign out_handle = out_handle_q;

	`SCBP_ASSERT(a_rd_delivers, clk, arst_n, state_q == scbp_pkg::B_RD |=> out_valid_q, "stack read did not produce an item")
	`SCBP_NEVER(a_no_pop_in_rd, clk, arst_n, state_q == scbp_pkg::B_RD && q_pop, "queue popped while a stack read is pending")
	`SCBP_NEVER(a_no_overwrite, clk, arst_n, load_out && out_valid_q && !out_ready, "result overwritten before it was taken")
	`SCBP_ASSERT(a_tally_grows, clk, arst_n, tally_q >= $past(tally_q), "kb tally decreased")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size class buffer pool testbench
// drives allocate and release items into the pool and keeps its own model of
// the free stacks, mint counts and kb tally to predict every status item;
// covers class boundaries, lifo reuse, bad releases, the kb limit and random
// traffic under several register settings, with random idling on both
// channels
// ----------------------------------------------------------------------------
module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam logic [scbp_pkg::REG_IDX_W-1:0] REG_PREALLOC_4K = 3'd1;

	typedef enum int {
		SC_4K, SC_16K, SC_64K, SC_256K, SC_1M, SC_4M, SC_8M, SC_UNKNOWN
	} size_class_t;
	typedef enum int {PRE_DEFAULT, PRE_ZERO, PRE_FULL, PRE_RANDOM} prealloc_mode_t;

	typedef struct packed {
		scbp_pkg::status_t             code;
		logic [scbp_pkg::CLASS_W-1:0]  cls;
		logic [scbp_pkg::HANDLE_W-1:0] hnd;
	} grant_t;

	typedef struct packed {
		logic [scbp_pkg::CLASS_W-1:0]  cls;
		logic [scbp_pkg::HANDLE_W-1:0] hnd;
	} buffer_ref_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [scbp_pkg::PADDR_W-1:0]  paddr;
	logic [scbp_pkg::PDATA_W-1:0]  pwdata;
	logic [scbp_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic                          action;
	logic [scbp_pkg::BYTES_W-1:0]  request_bytes;
	logic [scbp_pkg::CLASS_W-1:0]  release_class;
	logic [scbp_pkg::HANDLE_W-1:0] release_handle;
	logic                          out_valid;
	logic                          out_ready;
	logic [2:0]                    status;
	logic [scbp_pkg::CLASS_W-1:0]  granted_class;
	logic [scbp_pkg::HANDLE_W-1:0] granted_handle;

	// pool model state
	logic [scbp_pkg::HANDLE_W-1:0] free_slots [scbp_pkg::NUM_CLASSES][scbp_pkg::HANDLES];
	int unsigned                   free_depth [scbp_pkg::NUM_CLASSES];
	int unsigned                   mint_count [scbp_pkg::NUM_CLASSES];
	int unsigned                   prealloc_cfg [scbp_pkg::NUM_CLASSES];
	logic [scbp_pkg::LIMIT_W-1:0]  kb_tally;
	logic [scbp_pkg::LIMIT_W-1:0]  limit_kb;

	grant_t      awaited_grants [$];
	buffer_ref_t held_buffers [$];
	int          fail_count = 0;
	bit          throttle_on = 1'b0;

	size_class_buffer_pool uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.request_bytes  (request_bytes),
		.release_class  (release_class),
		.release_handle (release_handle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.granted_class  (granted_class),
		.granted_handle (granted_handle)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned kb_of_class(input int c);
		case (c)
			SC_4K:   return 4;
			SC_16K:  return 16;
			SC_64K:  return 64;
			SC_256K: return 256;
			SC_1M:   return 1024;
			SC_4M:   return 4096;
			default: return 8192;
		endcase
	endfunction

	function automatic logic [scbp_pkg::COUNT_W-1:0] default_prealloc(input int c);
		case (c)
			SC_4K:   return 14'd5000;
			SC_16K:  return 14'd1000;
			SC_64K:  return 14'd500;
			SC_256K: return 14'd200;
			SC_1M:   return 14'd50;
			SC_4M:   return 14'd20;
			default: return 14'd10;
		endcase
	endfunction

	function automatic longint unsigned prealloc_kb_sum();
		longint unsigned sum;
		sum = 0;
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++)
			sum += longint'(prealloc_cfg[c]) * kb_of_class(c);
		return sum;
	endfunction

	function automatic logic [scbp_pkg::BYTES_W-1:0] rand_bytes_for(input int c);
		int unsigned lo;
		int unsigned hi;
		hi = kb_of_class(c) * 1024;
		if (c == 0)
			lo = 0;
		else
			lo = kb_of_class(c - 1) * 1024 + 1;
		case ($urandom_range(7, 0))
			0:       return scbp_pkg::BYTES_W'(lo);
			1:       return scbp_pkg::BYTES_W'(hi);
			default: return scbp_pkg::BYTES_W'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic pool_reset();
		limit_kb = scbp_pkg::LIMIT_RESET;
		kb_tally = '0;
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
			prealloc_cfg[c] = default_prealloc(c);
			free_depth[c] = 0;
			mint_count[c] = 0;
		end
	endtask

	task automatic pool_predict(input logic act, input logic [scbp_pkg::BYTES_W-1:0] bytes,
			input logic [scbp_pkg::CLASS_W-1:0] rcls,
			input logic [scbp_pkg::HANDLE_W-1:0] rhnd);
		grant_t          g;
		int              c;
		bit              paid;
		longint unsigned need;
		longint unsigned grown;
		g = '0;
		if (act == scbp_pkg::ACT_ALLOC) begin
			c = -1;
			for (int k = scbp_pkg::NUM_CLASSES - 1; k >= 0; k--)
				if (bytes <= kb_of_class(k) * 1024)
					c = k;
			if (c < 0) begin
				g.code = scbp_pkg::ST_TOO_LARGE;
			end else if (free_depth[c] > 0) begin
				free_depth[c]--;
				g.code = scbp_pkg::ST_ALLOCATED;
				g.cls = scbp_pkg::CLASS_W'(c);
				g.hnd = free_slots[c][free_depth[c]];
			end else if (mint_count[c] >= scbp_pkg::HANDLES) begin
				g.code = scbp_pkg::ST_EXHAUSTED;
			end else begin
				paid = mint_count[c] >= prealloc_cfg[c];
				need = prealloc_kb_sum() + kb_tally + kb_of_class(c);
				if (paid && need >= limit_kb) begin
					g.code = scbp_pkg::ST_OVER_LIMIT;
				end else begin
					if (paid) begin
						grown = kb_tally + longint'(kb_of_class(c));
						kb_tally = (grown > 64'hFFFF_FFFF) ? '1 :
							scbp_pkg::LIMIT_W'(grown);
					end
					g.code = scbp_pkg::ST_ALLOCATED;
					g.cls = scbp_pkg::CLASS_W'(c);
					g.hnd = scbp_pkg::HANDLE_W'(mint_count[c]);
					mint_count[c]++;
				end
			end
		end else begin
			if (rcls >= scbp_pkg::NUM_CLASSES || free_depth[rcls] >= scbp_pkg::HANDLES) begin
				g.code = scbp_pkg::ST_BAD_RELEASE;
			end else begin
				free_slots[rcls][free_depth[rcls]] = rhnd;
				free_depth[rcls]++;
				g.code = scbp_pkg::ST_RELEASED;
			end
		end
		if (g.code == scbp_pkg::ST_ALLOCATED)
			held_buffers.push_back('{cls: g.cls, hnd: g.hnd});
		awaited_grants.push_back(g);
	endtask

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic send_item(input logic act, input logic [scbp_pkg::BYTES_W-1:0] bytes,
			input logic [scbp_pkg::CLASS_W-1:0] rcls,
			input logic [scbp_pkg::HANDLE_W-1:0] rhnd);
		if (throttle_on && $urandom_range(3, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		request_bytes <= bytes;
		release_class <= rcls;
		release_handle <= rhnd;
		do @(posedge clk); while (!in_ready);
		pool_predict(act, bytes, rcls, rhnd);
	endtask

	task automatic send_alloc(input logic [scbp_pkg::BYTES_W-1:0] bytes);
		send_item(scbp_pkg::ACT_ALLOC, bytes, scbp_pkg::CLASS_W'($urandom),
			scbp_pkg::HANDLE_W'($urandom));
	endtask

	task automatic send_release(input logic [scbp_pkg::CLASS_W-1:0] rcls,
			input logic [scbp_pkg::HANDLE_W-1:0] rhnd);
		send_item(scbp_pkg::ACT_RELEASE, scbp_pkg::BYTES_W'($urandom), rcls, rhnd);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_grants.size() != 0);
	endtask

	task automatic write_register(input logic [scbp_pkg::REG_IDX_W-1:0] idx,
			input logic [scbp_pkg::PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == scbp_pkg::REG_LIMIT)
			limit_kb = value;
		else
			prealloc_cfg[idx - REG_PREALLOC_4K] = value[scbp_pkg::COUNT_W-1:0];
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [scbp_pkg::LIMIT_W-1:0] limit,
			input prealloc_mode_t mode);
		logic [scbp_pkg::COUNT_W-1:0] v;
		write_register(scbp_pkg::REG_LIMIT, limit);
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
			case (mode)
				PRE_DEFAULT: v = default_prealloc(c);
				PRE_ZERO:    v = '0;
				PRE_FULL:    v = scbp_pkg::COUNT_W'(scbp_pkg::HANDLES);
				default:     v = scbp_pkg::COUNT_W'($urandom_range(scbp_pkg::HANDLES, 0));
			endcase
			write_register(REG_PREALLOC_4K + scbp_pkg::REG_IDX_W'(c),
				scbp_pkg::PDATA_W'(v));
		end
	endtask

	task automatic random_traffic(input int n);
		int pause_at;
		int pick;
		int k;
		pause_at = $urandom_range(n - 1, 0);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				wait_drained();
			pick = $urandom_range(99, 0);
			if (pick < 45) begin
				send_alloc(rand_bytes_for($urandom_range(scbp_pkg::NUM_CLASSES - 1, 0)));
			end else if (pick < 50) begin
				send_alloc(scbp_pkg::BYTES_W'($urandom_range(32'h7FFF_FFFF, 32'h0080_0001)));
			end else if (pick < 85 && held_buffers.size() > 0) begin
				k = $urandom_range(held_buffers.size() - 1, 0);
				send_release(held_buffers[k].cls, held_buffers[k].hnd);
				held_buffers.delete(k);
			end else begin
				send_release(scbp_pkg::CLASS_W'($urandom_range(7, 0)),
					scbp_pkg::HANDLE_W'($urandom));
			end
		end
	endtask

	task automatic test_directed_edges();
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++) begin
			send_alloc(scbp_pkg::BYTES_W'(kb_of_class(c) * 1024));
			send_alloc(scbp_pkg::BYTES_W'(kb_of_class(c) * 1024 + 1));
		end
		send_alloc('0);
		send_alloc('1);
		// lifo reuse
		send_release(scbp_pkg::CLASS_W'(SC_8M), '1);
		send_release(scbp_pkg::CLASS_W'(SC_8M), '0);
		repeat (2) send_alloc(scbp_pkg::BYTES_W'(kb_of_class(SC_8M) * 1024));
		send_release(scbp_pkg::CLASS_W'(SC_UNKNOWN), '1);
		send_release(scbp_pkg::CLASS_W'(SC_4K), '0);
		send_alloc(scbp_pkg::BYTES_W'(1));
	endtask

	task automatic test_memory_limit();
		wait_drained();
		apply_settings('0, PRE_ZERO);
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++)
			while (free_depth[c] != 0)
				send_alloc(rand_bytes_for(c));
		for (int c = 0; c < scbp_pkg::NUM_CLASSES; c++)
			send_alloc(rand_bytes_for(c));
		wait_drained();
		// room for three 4k mints
		write_register(scbp_pkg::REG_LIMIT, kb_tally + 32'd13);
		repeat (5) send_alloc(rand_bytes_for(SC_4K));
		wait_drained();
		// need lands exactly on the limit
		write_register(scbp_pkg::REG_LIMIT, kb_tally + 32'd4);
		send_alloc(rand_bytes_for(SC_4K));
		wait_drained();
		write_register(REG_PREALLOC_4K + scbp_pkg::REG_IDX_W'(SC_8M),
			scbp_pkg::PDATA_W'(scbp_pkg::HANDLES));
		write_register(scbp_pkg::REG_LIMIT,
			scbp_pkg::LIMIT_W'(prealloc_kb_sum()) + kb_tally + 32'd5);
		repeat (2) send_alloc(rand_bytes_for(SC_4K));
		repeat (2) send_alloc(rand_bytes_for(SC_8M));
	endtask

	task automatic test_random_settings();
		wait_drained();
		apply_settings(scbp_pkg::LIMIT_RESET, PRE_DEFAULT);
		random_traffic(250);
		wait_drained();
		apply_settings('1, PRE_FULL);
		random_traffic(250);
		wait_drained();
		apply_settings('0, PRE_ZERO);
		write_register(scbp_pkg::REG_LIMIT, kb_tally + 32'd40000);
		random_traffic(250);
		wait_drained();
		apply_settings(scbp_pkg::LIMIT_W'($urandom), PRE_RANDOM);
		random_traffic(250);
	endtask

	always begin
		@(posedge clk);
		if (throttle_on && $urandom_range(5, 0) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		out_ready <= 1'b1;
	end

	always @(posedge clk) begin : result_check
		grant_t want;
		if (out_valid && out_ready) begin
			if (awaited_grants.size() == 0) begin
				note_mismatch("result with no item pending");
			end else begin
				want = awaited_grants.pop_front();
				if (status !== want.code)
					note_mismatch($sformatf("status %0d, want %0d", status, want.code));
				if (granted_class !== want.cls)
					note_mismatch($sformatf("class %0d, want %0d", granted_class, want.cls));
				if (granted_handle !== want.hnd)
					note_mismatch($sformatf("handle %0d, want %0d", granted_handle, want.hnd));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		pool_reset();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		action <= scbp_pkg::ACT_ALLOC;
		request_bytes <= '0;
		release_class <= '0;
		release_handle <= '0;
		out_ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		throttle_on = 1'b1;
		test_directed_edges();
		test_memory_limit();
		test_random_settings();
		throttle_on = 1'b0;
		random_traffic(250);
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && awaited_grants.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
